// File: rtl/dsf_pkg.sv
// ----------------------------------------------------------------------------
// dsf_pkg: shared types and codes for the dual-stream packet FIFO
// Transaction formats, command, status and policy codes, default sizes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package dsf_pkg;

    localparam int DEF_RING_DEPTH   = 16;
    localparam int DEF_PACKET_WIDTH = 32;

    // APB address: one register at byte address 0
    localparam int ADDR_W = 3;
    localparam logic [ADDR_W-3:0] REG_OVERFLOW_POLICY = 1'b0;

    localparam logic [1:0] CMD_PUSH = 2'd0;
    localparam logic [1:0] CMD_POP  = 2'd1;
    localparam logic [1:0] CMD_EOS  = 2'd2;

    localparam logic [1:0] POL_REJECT   = 2'd0;
    localparam logic [1:0] POL_DROP     = 2'd1;
    localparam logic [1:0] POL_HOLD     = 2'd2;
    localparam logic [1:0] POL_RESERVED = 2'd3;

    localparam logic [2:0] ST_OK     = 3'd0;
    localparam logic [2:0] ST_EMPTY  = 3'd1;
    localparam logic [2:0] ST_EOS    = 3'd2;
    localparam logic [2:0] ST_FULL   = 3'd3;
    localparam logic [2:0] ST_CLOSED = 3'd4;
    localparam logic [2:0] ST_RETRY  = 3'd5;

    typedef struct packed {
        logic [1:0]  command;
        logic        stream_select;
        logic [31:0] payload;
    } cmd_item_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] data_out;
        logic [4:0]  fill_count;
        logic        stream_drained;
    } rsp_item_t;

    // result fields known at accept time; data comes from the store read
    typedef struct packed {
        logic [2:0] status;
        logic       pop_ok;
        logic [4:0] fill_count;
        logic       stream_drained;
    } rsp_meta_t;

    typedef struct packed {
        logic we;
        logic re;
    } store_ctl_t;

endpackage

`default_nettype wire

// File: rtl/dsf_cfg.sv
// ----------------------------------------------------------------------------
// dsf_cfg: APB configuration register
// Holds the overflow policy; pready is tied high.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dsf_cfg
    import dsf_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [31:0]       pwdata,
    output logic      [31:0]       prdata,
    output logic                   pready,
    output logic      [1:0]        policy
);

    logic [1:0] policy_reg;
    logic [1:0] policy_next;
    logic       hit;

    assign hit    = (paddr[ADDR_W-1:2] == REG_OVERFLOW_POLICY);
    assign pready = 1'b1;
    assign policy = policy_reg;
    assign prdata = hit ? {30'b0, policy_reg} : 32'b0;

    always_comb
    begin
        policy_next = policy_reg;
        if (psel && penable && pwrite && pready && hit)
        begin
            policy_next = pwdata[1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            policy_reg <= POL_REJECT;
        end
        else
        begin
            policy_reg <= policy_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/dsf_store.sv
// ----------------------------------------------------------------------------
// dsf_store: packet word memory for both rings
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dsf_store
    import dsf_pkg::*;
#(
    parameter int RING_DEPTH   = DEF_RING_DEPTH,
    parameter int PACKET_WIDTH = DEF_PACKET_WIDTH,
    localparam int PTR_W       = $clog2(RING_DEPTH)
)
(
    input  wire logic                    clk,
    input  wire store_ctl_t              ctl,
    input  wire logic [PTR_W:0]          waddr,
    input  wire logic [PACKET_WIDTH-1:0] wdata,
    input  wire logic [PTR_W:0]          raddr,
    output logic      [PACKET_WIDTH-1:0] rdata
);

    localparam int ENTRIES = 2 << PTR_W;

    logic [PACKET_WIDTH-1:0] mem [ENTRIES];
    logic [PACKET_WIDTH-1:0] rdata_reg;

    assign rdata = rdata_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// File: rtl/dsf_ctrl.sv
// ----------------------------------------------------------------------------
// dsf_ctrl: ring pointer control and result register
// Serves push, pop and end-of-stream, applies the overflow policy.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dsf_ctrl
    import dsf_pkg::*;
#(
    parameter int RING_DEPTH   = DEF_RING_DEPTH,
    parameter int PACKET_WIDTH = DEF_PACKET_WIDTH,
    localparam int PTR_W       = $clog2(RING_DEPTH),
    localparam int CNT_W       = $clog2(RING_DEPTH + 1)
)
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic [1:0]              policy,
    input  wire logic                    cmd_valid,
    input  wire cmd_item_t               cmd_item,
    output logic                         cmd_ready,
    output logic                         rsp_valid,
    input  wire logic                    rsp_ready,
    output rsp_meta_t                    meta,
    output store_ctl_t                   ctl,
    output logic      [PTR_W:0]          waddr,
    output logic      [PACKET_WIDTH-1:0] wdata,
    output logic      [PTR_W:0]          raddr
);

    logic [PTR_W-1:0] rp_reg   [2];
    logic [PTR_W-1:0] rp_next  [2];
    logic [PTR_W-1:0] wp_reg   [2];
    logic [PTR_W-1:0] wp_next  [2];
    logic [CNT_W-1:0] cnt_reg  [2];
    logic [CNT_W-1:0] cnt_next [2];
    logic [1:0]       ended_reg;
    logic [1:0]       ended_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    rsp_meta_t        meta_reg;
    rsp_meta_t        meta_next;
    logic             accept;
    logic [PACKET_WIDTH+31:0] pay_ext;

    function automatic logic [PTR_W-1:0] adv(input logic [PTR_W-1:0] p);
        adv = (p == PTR_W'(RING_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign cmd_ready = !out_valid_reg || rsp_ready;
    assign accept    = cmd_valid && cmd_ready;
    assign rsp_valid = out_valid_reg;
    assign meta      = meta_reg;
    assign pay_ext   = {{PACKET_WIDTH{1'b0}}, cmd_item.payload};
    assign wdata     = pay_ext[PACKET_WIDTH-1:0];

    always_comb
    begin
        logic             sel;
        logic [1:0]       pol;
        logic [2:0]       status;
        logic             pop_ok;
        logic [CNT_W+4:0] fill_ext;

        sel        = cmd_item.stream_select;
        status     = ST_OK;
        pop_ok     = 1'b0;
        ctl        = '0;
        waddr      = {sel, wp_reg[sel]};
        raddr      = {sel, rp_reg[sel]};
        rp_next    = rp_reg;
        wp_next    = wp_reg;
        cnt_next   = cnt_reg;
        ended_next = ended_reg;

        case (policy)
            POL_DROP: pol = POL_DROP;
            POL_HOLD: pol = POL_HOLD;
            default:  pol = POL_REJECT;
        endcase

        if (accept)
        begin
            case (cmd_item.command)
                CMD_PUSH:
                begin
                    if (ended_reg[sel])
                    begin
                        status = (pol == POL_REJECT) ? ST_FULL : ST_CLOSED;
                    end
                    else if (cnt_reg[sel] == CNT_W'(RING_DEPTH))
                    begin
                        case (pol)
                            POL_DROP:
                            begin
                                // discard the head, keep the count at depth
                                rp_next[sel] = adv(rp_reg[sel]);
                                wp_next[sel] = adv(wp_reg[sel]);
                                ctl.we       = 1'b1;
                            end
                            POL_HOLD: status = ST_RETRY;
                            default:  status = ST_FULL;
                        endcase
                    end
                    else
                    begin
                        wp_next[sel]  = adv(wp_reg[sel]);
                        cnt_next[sel] = cnt_reg[sel] + 1'b1;
                        ctl.we        = 1'b1;
                    end
                end
                CMD_POP:
                begin
                    if (cnt_reg[sel] == '0)
                    begin
                        status = ended_reg[sel] ? ST_EOS : ST_EMPTY;
                    end
                    else
                    begin
                        rp_next[sel]  = adv(rp_reg[sel]);
                        cnt_next[sel] = cnt_reg[sel] - 1'b1;
                        ctl.re        = 1'b1;
                        pop_ok        = 1'b1;
                    end
                end
                CMD_EOS:
                begin
                    ended_next = 2'b11;
                end
                default:
                begin
                end
            endcase
        end

        fill_ext                 = {5'b0, cnt_next[sel]};
        meta_next.status         = status;
        meta_next.pop_ok         = pop_ok;
        meta_next.fill_count     = fill_ext[4:0];
        meta_next.stream_drained = ended_next[sel] && (cnt_next[sel] == '0);

        if (accept)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rp_reg        <= '{default: '0};
            wp_reg        <= '{default: '0};
            cnt_reg       <= '{default: '0};
            ended_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            rp_reg        <= rp_next;
            wp_reg        <= wp_next;
            cnt_reg       <= cnt_next;
            ended_reg     <= ended_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            meta_reg <= meta_next;
        end
    end

`ifndef SYNTHESIS
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg[0] <= CNT_W'(RING_DEPTH) && cnt_reg[1] <= CNT_W'(RING_DEPTH))
        else $error("ring count above depth");

    a_ptr_empty_full0: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg[0] == '0 || cnt_reg[0] == CNT_W'(RING_DEPTH)) |-> rp_reg[0] == wp_reg[0])
        else $error("video ring pointers disagree with count");

    a_ptr_empty_full1: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg[1] == '0 || cnt_reg[1] == CNT_W'(RING_DEPTH)) |-> rp_reg[1] == wp_reg[1])
        else $error("audio ring pointers disagree with count");

    a_eos_closes: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && cmd_item.command == CMD_EOS) |=> ended_reg == 2'b11)
        else $error("end of stream did not close both rings");

    a_retry_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && meta_next.status == ST_RETRY)
            |=> cnt_reg[0] == $past(cnt_reg[0]) && cnt_reg[1] == $past(cnt_reg[1])
                && wp_reg[0] == $past(wp_reg[0]) && wp_reg[1] == $past(wp_reg[1]))
        else $error("retry changed ring state");
`endif

endmodule

`default_nettype wire

// File: rtl/dual_stream_packet_fifo_core.sv
// ----------------------------------------------------------------------------
// dual_stream_packet_fifo_core: two ring FIFOs (video, audio) in one memory
// Push, pop and end-of-stream commands with a configurable overflow policy.
//
//   channel   signals                                  role
//   cmd       cmd_valid / cmd_ready / cmd_item         command transaction in
//   rsp       rsp_valid / rsp_ready / rsp_item         one result per command
//   apb       psel penable pwrite paddr pwdata prdata  overflow policy register
//
// One command transaction per cycle while cmd_ready is high; its result
// appears from the result register in the next cycle, pop data straight
// from the registered memory read. cmd_ready drops only while a result
// waits and rsp_ready is low. Reset clears pointers, counts and end-of-stream
// flags at once; the word memory is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dual_stream_packet_fifo_core
    import dsf_pkg::*;
#(
    parameter int RING_DEPTH   = DEF_RING_DEPTH,
    parameter int PACKET_WIDTH = DEF_PACKET_WIDTH
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cmd_valid,
    output logic                   cmd_ready,
    input  wire cmd_item_t         cmd_item,
    output logic                   rsp_valid,
    input  wire logic              rsp_ready,
    output rsp_item_t              rsp_item,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [31:0]       pwdata,
    output logic      [31:0]       prdata,
    output logic                   pready
);

    localparam int PTR_W = $clog2(RING_DEPTH);

    logic [1:0]              policy;
    rsp_meta_t               meta;
    store_ctl_t              ctl;
    logic [PTR_W:0]          waddr;
    logic [PTR_W:0]          raddr;
    logic [PACKET_WIDTH-1:0] wdata;
    logic [PACKET_WIDTH-1:0] rdata;
    logic [PACKET_WIDTH+31:0] rdata_ext;

    dsf_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .policy  (policy)
    );

    dsf_ctrl #(
        .RING_DEPTH   (RING_DEPTH),
        .PACKET_WIDTH (PACKET_WIDTH)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .policy    (policy),
        .cmd_valid (cmd_valid),
        .cmd_item  (cmd_item),
        .cmd_ready (cmd_ready),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .meta      (meta),
        .ctl       (ctl),
        .waddr     (waddr),
        .wdata     (wdata),
        .raddr     (raddr)
    );

    dsf_store #(
        .RING_DEPTH   (RING_DEPTH),
        .PACKET_WIDTH (PACKET_WIDTH)
    ) u_store (
        .clk   (clk),
        .ctl   (ctl),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    // fit the stored word to the 32-bit result field
    assign rdata_ext = {32'b0, rdata};

    always_comb
    begin
        rsp_item.status         = meta.status;
        rsp_item.data_out       = meta.pop_ok ? rdata_ext[31:0] : 32'b0;
        rsp_item.fill_count     = meta.fill_count;
        rsp_item.stream_drained = meta.stream_drained;
    end

endmodule

`default_nettype wire
